>>> rtl/gnig_pkg.sv
// Shared types and constants for the grid neighbour index generator.
// Used by the front, queue, back and top-level modules; depends on nothing.
package gnig_pkg;

	localparam int IDX_W       = 30;
	localparam int SIZE_W      = 11;
	localparam int CRD_W       = 11;
	localparam int PROD_W      = 2 * SIZE_W;
	localparam int NDIM        = 3;
	localparam int OFS_W       = 5;
	localparam int DIV_STEPS   = 5;
	localparam int DIV_CYCLES  = IDX_W / DIV_STEPS;
	localparam int DCNT_W      = $clog2(DIV_CYCLES);
	localparam int QUEUE_DEPTH = 2;

	// Per-axis offset digits: -1, 0 and +1.
	localparam logic [1:0] DIG_MINUS = 2'd0;
	localparam logic [1:0] DIG_ZERO  = 2'd1;
	localparam logic [1:0] DIG_PLUS  = 2'd2;

	// Offset number of the final neighbour for one, two and three dimensions.
	localparam logic [OFS_W-1:0] LAST_OFS_1D = 5'd1;
	localparam logic [OFS_W-1:0] LAST_OFS_2D = 5'd7;
	localparam logic [OFS_W-1:0] LAST_OFS_3D = 5'd25;

	typedef enum logic [1:0] {
		REG_NUM_DIMS,
		REG_DIM_SIZE_0,
		REG_DIM_SIZE_1,
		REG_DIM_SIZE_2
	} reg_idx_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_DIV,
		FS_MUL1,
		FS_MUL2,
		FS_PUSH
	} front_state_t;

	// Effective configuration after clamping.
	typedef struct packed {
		logic [1:0]                  num_dims;
		logic [NDIM-1:0][SIZE_W-1:0] size;
	} grid_cfg_t;

	// One decoded centre cell on its way from the front to the back.
	typedef struct packed {
		logic [IDX_W-1:0]           base;
		logic [NDIM-1:0][CRD_W-1:0] crd;
		logic [PROD_W-1:0]          s01;
	} item_rec_t;

	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

	function automatic logic [OFS_W-1:0] last_offset(input logic [1:0] n);
		logic [OFS_W-1:0] r;
		case (n)
			2'd1: r = LAST_OFS_1D;
			2'd2: r = LAST_OFS_2D;
			default: r = LAST_OFS_3D;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/gnig_front.sv
// Front end: accepts a centre index, splits it into coordinates with an
// iterative divider and rebuilds the wrapped base index. Depends on gnig_pkg.
module gnig_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [29:0]         centre_index,
	input  gnig_pkg::grid_cfg_t cfg,
	input  gnig_pkg::q_stat_t   q_stat,
	output logic                push,
	output gnig_pkg::item_rec_t push_data
);
	import gnig_pkg::*;

	front_state_t state_q, state_d;

	logic [DCNT_W-1:0]          cnt_q;
	logic [1:0]                 dim_q;
	logic [SIZE_W-1:0]          rem_q;
	logic [IDX_W-1:0]           quo_q;
	logic [NDIM-1:0][CRD_W-1:0] crd_q;
	logic [PROD_W-1:0]          prod_a_q;
	logic [PROD_W-1:0]          s01_q;
	logic [IDX_W-1:0]           prod_b_q;

	logic [SIZE_W-1:0]          divisor;
	logic [SIZE_W:0]            div_sh;
	logic [SIZE_W-1:0]          div_r;
	logic [IDX_W-1:0]           div_q;
	logic                       div_end;
	logic                       dim_last;
	logic [CRD_W+PROD_W-1:0]    prod_b_w;

	// Restoring division, several quotient bits per cycle. The quotient
	// shifts in where the dividend bits shift out.
	always_comb begin
		divisor = cfg.size[dim_q];
		div_r   = rem_q;
		div_q   = quo_q;
		div_sh  = '0;
		for (int j = 0; j < DIV_STEPS; j++) begin
			div_sh = {div_r, div_q[IDX_W-1]};
			div_q  = {div_q[IDX_W-2:0], 1'b0};
			if (div_sh >= {1'b0, divisor}) begin
				div_sh   = div_sh - {1'b0, divisor};
				div_q[0] = 1'b1;
			end
			div_r = div_sh[SIZE_W-1:0];
		end
	end

	assign div_end  = (cnt_q == DCNT_W'(DIV_CYCLES - 1));
	assign dim_last = (dim_q == 2'(cfg.num_dims - 2'd1));
	assign prod_b_w = (CRD_W+PROD_W)'(crd_q[2]) * (CRD_W+PROD_W)'(s01_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		push    = 1'b0;
		case (state_q)
			FS_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = FS_DIV;
				end
			end
			FS_DIV: begin
				if (div_end && dim_last) begin
					state_d = FS_MUL1;
				end
			end
			FS_MUL1: begin
				state_d = FS_MUL2;
			end
			FS_MUL2: begin
				state_d = FS_PUSH;
			end
			FS_PUSH: begin
				push = !q_stat.full;
				if (!q_stat.full) begin
					state_d = FS_IDLE;
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			dim_q <= '0;
		end else if (state_q == FS_IDLE) begin
			cnt_q <= '0;
			dim_q <= '0;
		end else if (state_q == FS_DIV) begin
			if (div_end) begin
				cnt_q <= '0;
				dim_q <= dim_q + 2'd1;
			end else begin
				cnt_q <= cnt_q + DCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FS_IDLE: begin
				if (start) begin
					quo_q <= centre_index;
					rem_q <= '0;
					crd_q <= '0;
				end
			end
			FS_DIV: begin
				quo_q <= div_q;
				if (div_end) begin
					// The top dimension keeps only the remainder, so an index
					// beyond the grid wraps there.
					crd_q[dim_q] <= div_r[CRD_W-1:0];
					rem_q        <= '0;
				end else begin
					rem_q <= div_r;
				end
			end
			FS_MUL1: begin
				prod_a_q <= PROD_W'(crd_q[1]) * PROD_W'(cfg.size[0]);
				s01_q    <= PROD_W'(cfg.size[0]) * PROD_W'(cfg.size[1]);
			end
			FS_MUL2: begin
				prod_b_q <= prod_b_w[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign push_data.base = IDX_W'(crd_q[0]) + IDX_W'(prod_a_q) + prod_b_q;
	assign push_data.crd  = crd_q;
	assign push_data.s01  = s01_q;

endmodule

>>> rtl/gnig_queue.sv
// Short queue of decoded centre cells between the front and the back end.
// Depends on gnig_pkg.
module gnig_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gnig_pkg::item_rec_t push_data,
	input  logic                pop,
	output gnig_pkg::item_rec_t pop_data,
	output gnig_pkg::q_stat_t   stat
);
	import gnig_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_rec_t          entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data   = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.avail = (count_q != '0);

endmodule

>>> rtl/gnig_back.sv
// Back end: walks the Moore offsets of one decoded centre cell and issues
// one neighbour per cycle through output registers. Depends on gnig_pkg.
module gnig_back (
	input  logic                clk,
	input  logic                arst_n,
	input  gnig_pkg::grid_cfg_t cfg,
	input  gnig_pkg::q_stat_t   q_stat,
	input  gnig_pkg::item_rec_t q_data,
	output logic                pop,
	output logic                result_strobe,
	output logic [29:0]         neighbour_index,
	output logic                neighbour_valid,
	output logic [4:0]          offset_number,
	output logic                last_neighbour
);
	import gnig_pkg::*;

	logic                       act_q;
	logic [OFS_W-1:0]           k_q;
	logic [NDIM-1:0][1:0]       d_q;
	item_rec_t                  rec_q;

	logic [OFS_W-1:0]           last_k;
	logic                       is_last;
	logic [NDIM-1:0][1:0]       d_init;
	logic [NDIM-1:0][1:0]       d_one;
	logic [NDIM-1:0][1:0]       d_next;
	logic [NDIM-1:0][1:0]       centre;
	logic [NDIM-1:0][IDX_W-1:0] stride;
	logic                       all_in;
	logic [IDX_W-1:0]           idx;

	logic                       strobe_q;
	logic [IDX_W-1:0]           index_q;
	logic                       valid_q;
	logic [OFS_W-1:0]           ofs_q;
	logic                       last_q;

	// Base-3 increment over the dimensions in use, dimension 0 fastest.
	function automatic logic [NDIM-1:0][1:0] step3(input logic [NDIM-1:0][1:0] d,
			input logic [1:0] n);
		logic [NDIM-1:0][1:0] r;
		logic                 carry;
		r     = d;
		carry = 1'b1;
		for (int i = 0; i < NDIM; i++) begin
			if (carry && (i < int'(n))) begin
				if (r[i] == DIG_PLUS) begin
					r[i] = DIG_MINUS;
				end else begin
					r[i]  = r[i] + 2'd1;
					carry = 1'b0;
				end
			end
		end
		return r;
	endfunction

	assign last_k  = last_offset(cfg.num_dims);
	assign is_last = act_q && (k_q == last_k);
	assign pop     = q_stat.avail && (!act_q || is_last);

	// Unused dimensions sit at the zero offset, so they never move the index
	// and never fail the bounds check.
	always_comb begin
		for (int i = 0; i < NDIM; i++) begin
			d_init[i] = (i < int'(cfg.num_dims)) ? DIG_MINUS : DIG_ZERO;
			centre[i] = DIG_ZERO;
		end
		d_one  = step3(d_q, cfg.num_dims);
		d_next = (d_one == centre) ? step3(d_one, cfg.num_dims) : d_one;
	end

	always_comb begin
		stride[0] = IDX_W'(1);
		stride[1] = IDX_W'(cfg.size[0]);
		stride[2] = IDX_W'(rec_q.s01);
		all_in    = 1'b1;
		idx       = rec_q.base;
		for (int i = 0; i < NDIM; i++) begin
			if ((d_q[i] == DIG_MINUS) && (rec_q.crd[i] == '0)) begin
				all_in = 1'b0;
			end
			if ((d_q[i] == DIG_PLUS) && (rec_q.crd[i] == CRD_W'(cfg.size[i] - SIZE_W'(1)))) begin
				all_in = 1'b0;
			end
			if (d_q[i] == DIG_PLUS) begin
				idx = idx + stride[i];
			end else if (d_q[i] == DIG_MINUS) begin
				idx = idx - stride[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			k_q      <= '0;
			d_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= act_q;
			if (pop) begin
				act_q <= 1'b1;
				k_q   <= '0;
				d_q   <= d_init;
			end else if (is_last) begin
				act_q <= 1'b0;
			end else if (act_q) begin
				k_q <= k_q + OFS_W'(1);
				d_q <= d_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= q_data;
		end
		index_q <= all_in ? idx : '0;
		valid_q <= all_in;
		ofs_q   <= k_q;
		last_q  <= (k_q == last_k);
	end

	assign result_strobe   = strobe_q;
	assign neighbour_index = index_q;
	assign neighbour_valid = valid_q;
	assign offset_number   = ofs_q;
	assign last_neighbour  = last_q;

endmodule

>>> rtl/grid_neighbour_index_generator_core.sv
// Grid neighbour index generator, top level: configuration registers,
// clamping, and the front, queue and back ends. Depends on gnig_pkg.
//
// Use: configure num_dims and the dimension sizes over the APB-style port
// (registers at byte addresses 0, 4, 8 and 12) while the block is idle.
// Pulse start with a centre_index while busy is low; the item is taken at
// that edge. The block answers with 3^n-1 results, one per cycle, each shown
// for exactly one cycle with result_strobe high, in offset order with
// dimension 0 fastest; last_neighbour marks the final one.
// Flow: the front end divides the item once per dimension in use, its
// divider retiring five quotient bits a cycle, then builds the base index
// in its MUL1 and MUL2 states and pushes it into the queue from PUSH, where
// a full queue holds it; busy stays high until the push. The back end pops
// the item and issues its results through output registers. A two-entry
// queue lets the front end decode the next item while the back end is
// still issuing results.
// Reset: clears all control state and loads num_dims 2 and sizes 64, 64, 1.
// The receiver cannot stall; results are issued as they are produced.
module grid_neighbour_index_generator_core #(
	parameter int MAX_DIMS = 3,
	parameter int DIM_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [29:0] centre_index,
	output logic        result_strobe,
	output logic [29:0] neighbour_index,
	output logic        neighbour_valid,
	output logic [4:0]  offset_number,
	output logic        last_neighbour
);
	import gnig_pkg::*;

	localparam int SIZE_CAP = 1 << DIM_BITS;

	logic [1:0]                  num_dims_q;
	logic [NDIM-1:0][SIZE_W-1:0] dim_size_q;
	logic                        wr_en;
	reg_idx_t                    reg_sel;
	grid_cfg_t                   cfg;

	logic                        push;
	logic                        pop;
	item_rec_t                   push_data;
	item_rec_t                   pop_data;
	q_stat_t                     q_stat;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q    <= 2'd2;
			dim_size_q[0] <= SIZE_W'(64);
			dim_size_q[1] <= SIZE_W'(64);
			dim_size_q[2] <= SIZE_W'(1);
		end else if (wr_en) begin
			case (reg_sel)
				REG_NUM_DIMS:   num_dims_q    <= pwdata[1:0];
				REG_DIM_SIZE_0: dim_size_q[0] <= pwdata[SIZE_W-1:0];
				REG_DIM_SIZE_1: dim_size_q[1] <= pwdata[SIZE_W-1:0];
				REG_DIM_SIZE_2: dim_size_q[2] <= pwdata[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_NUM_DIMS:   prdata = 32'(num_dims_q);
			REG_DIM_SIZE_0: prdata = 32'(dim_size_q[0]);
			REG_DIM_SIZE_1: prdata = 32'(dim_size_q[1]);
			REG_DIM_SIZE_2: prdata = 32'(dim_size_q[2]);
			default:        prdata = '0;
		endcase
	end

	// Out-of-range settings are clamped here so both ends see legal values.
	always_comb begin
		if (num_dims_q == 2'd0) begin
			cfg.num_dims = 2'd1;
		end else if (int'(num_dims_q) > MAX_DIMS) begin
			cfg.num_dims = 2'(MAX_DIMS);
		end else begin
			cfg.num_dims = num_dims_q;
		end
		for (int i = 0; i < NDIM; i++) begin
			if (dim_size_q[i] == '0) begin
				cfg.size[i] = SIZE_W'(1);
			end else if (int'(dim_size_q[i]) > SIZE_CAP) begin
				cfg.size[i] = SIZE_W'(SIZE_CAP);
			end else begin
				cfg.size[i] = dim_size_q[i];
			end
		end
	end

	gnig_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.centre_index (centre_index),
		.cfg          (cfg),
		.q_stat       (q_stat),
		.push         (push),
		.push_data    (push_data)
	);

	gnig_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	gnig_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.q_stat          (q_stat),
		.q_data          (pop_data),
		.pop             (pop),
		.result_strobe   (result_strobe),
		.neighbour_index (neighbour_index),
		.neighbour_valid (neighbour_valid),
		.offset_number   (offset_number),
		.last_neighbour  (last_neighbour)
	);

`ifndef SYNTHESIS
	a_last_offset: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_neighbour |-> offset_number == last_offset(cfg.num_dims))
		else $error("last neighbour carries the wrong offset number");

	a_burst_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_neighbour |=>
			result_strobe && (offset_number == $past(offset_number) + 5'd1))
		else $error("neighbour burst broken or out of order");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue written while full");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("front end not busy after taking an item");
`endif

endmodule
